/* src/itp_pkg.sv */
// itp_pkg: character classes, operator stack codes, precedences and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
package itp_pkg;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_LETTER,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP
  } char_class_t;

  localparam logic [2:0] CODE_OPEN  = 3'd0;
  localparam logic [2:0] CODE_PLUS  = 3'd1;
  localparam logic [2:0] CODE_MINUS = 3'd2;
  localparam logic [2:0] CODE_MUL   = 3'd3;
  localparam logic [2:0] CODE_DIV   = 3'd4;
  localparam logic [2:0] CODE_CARET = 3'd5;

  localparam logic [1:0] PREC_CARET = 2'd3;

  // Class as seen by the right-to-left scan: parentheses swap roles.
  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
      r = CLS_LETTER;
    end else begin
      case (c)
        "(":                          r = CLS_CLOSE;
        ")":                          r = CLS_OPEN;
        "+", "-", "*", "/", "^":      r = CLS_OP;
        default:                      r = CLS_OTHER;
      endcase
    end
    return r;
  endfunction

  function automatic logic [2:0] op_code(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      "+":     r = CODE_PLUS;
      "-":     r = CODE_MINUS;
      "*":     r = CODE_MUL;
      "/":     r = CODE_DIV;
      "^":     r = CODE_CARET;
      default: r = CODE_OPEN;
    endcase
    return r;
  endfunction

  // '(' ranks below every operator; 0 stands in for its negative rank.
  function automatic logic [1:0] prec(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      CODE_PLUS, CODE_MINUS: r = 2'd1;
      CODE_MUL, CODE_DIV:    r = 2'd2;
      CODE_CARET:            r = PREC_CARET;
      default:               r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(input logic [2:0] k);
    logic [7:0] r;
    case (k)
      CODE_OPEN:  r = "(";
      CODE_PLUS:  r = "+";
      CODE_MINUS: r = "-";
      CODE_MUL:   r = "*";
      CODE_DIV:   r = "/";
      CODE_CARET: r = "^";
      default:    r = 8'd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic load_char;
    logic scan_start;
    logic scan_read;
    logic load_cur;
    logic emit_cur;
    logic push;
    logic pop_emit;
    logic pop_drop;
    logic load_top;
    logic emit_start;
    logic emit_read;
    logic emit_put;
    logic emit_empty;
  } itp_cmd_t;

  typedef struct packed {
    char_class_t cls;
    logic [2:0]  cur_code;
    logic [2:0]  top_code;
    logic        depth_zero;
    logic        char_idx_zero;
    logic        res_count_zero;
    logic        res_idx_zero;
    logic        out_free;
  } itp_stat_t;

endpackage

/* src/itp_ram.sv */
// itp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/itp_ctrl.sv */
// itp_ctrl: sequencer for load, right-to-left scan, stack pops, drain and
// reversed emission. Depends on itp_pkg.
module itp_ctrl import itp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      last,
  input  itp_stat_t stat,
  output logic      in_stall,
  output itp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_SCAN,
    S_FETCH,
    S_DECIDE,
    S_RELOAD,
    S_DRAIN,
    S_EMIT_RD,
    S_EMIT_PUT,
    S_EMPTY
  } state_t;

  state_t state, state_next;
  state_t ret, ret_next;
  logic   in_loop, in_loop_next;
  logic   caret_mode, caret_mode_next;

  logic [1:0] p, tp;

  assign p  = prec(stat.cur_code);
  assign tp = prec(stat.top_code);
  assign in_stall = (state != S_LOAD);

  always_comb begin
    cmd             = '0;
    state_next      = state;
    ret_next        = ret;
    in_loop_next    = in_loop;
    caret_mode_next = caret_mode;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load_char = 1'b1;
          if (last) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        if (stat.char_idx_zero) begin
          state_next = S_DRAIN;
        end else begin
          cmd.scan_read = 1'b1;
          state_next    = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.load_cur = 1'b1;
        state_next   = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_SCAN;
        case (stat.cls)
          CLS_LETTER: cmd.emit_cur = 1'b1;
          CLS_OPEN:   cmd.push = 1'b1;
          CLS_CLOSE: begin
            if (!stat.depth_zero && stat.top_code != CODE_OPEN) begin
              cmd.pop_emit = 1'b1;
              ret_next     = S_DECIDE;
              state_next   = S_RELOAD;
            end else if (!stat.depth_zero) begin
              // drop the matching open parenthesis
              cmd.pop_drop = 1'b1;
              ret_next     = S_SCAN;
              state_next   = S_RELOAD;
            end
          end
          CLS_OP: begin
            if (!in_loop) begin
              if (stat.depth_zero || p > tp || (p == tp && stat.cur_code != CODE_CARET)) begin
                cmd.push = 1'b1;
              end else begin
                in_loop_next    = 1'b1;
                caret_mode_next = (p == tp);
                cmd.pop_emit    = 1'b1;
                ret_next        = S_DECIDE;
                state_next      = S_RELOAD;
              end
            end else if (!stat.depth_zero && (caret_mode ? (tp == PREC_CARET) : (p < tp))) begin
              cmd.pop_emit = 1'b1;
              ret_next     = S_DECIDE;
              state_next   = S_RELOAD;
            end else begin
              cmd.push     = 1'b1;
              in_loop_next = 1'b0;
            end
          end
          default: ;
        endcase
      end
      S_RELOAD: begin
        cmd.load_top = 1'b1;
        state_next   = ret;
      end
      S_DRAIN: begin
        if (!stat.depth_zero) begin
          cmd.pop_emit = 1'b1;
          ret_next     = S_DRAIN;
          state_next   = S_RELOAD;
        end else if (stat.res_count_zero) begin
          state_next = S_EMPTY;
        end else begin
          cmd.emit_start = 1'b1;
          state_next     = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_read = 1'b1;
        state_next    = S_EMIT_PUT;
      end
      S_EMIT_PUT: begin
        if (stat.out_free) begin
          cmd.emit_put = 1'b1;
          state_next   = stat.res_idx_zero ? S_LOAD : S_EMIT_RD;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      ret        <= S_SCAN;
      in_loop    <= 1'b0;
      caret_mode <= 1'b0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      in_loop    <= in_loop_next;
      caret_mode <= caret_mode_next;
    end
  end

endmodule

/* src/itp_dp.sv */
// itp_dp: character, operator stack and result memories, counters, top and
// current-character registers, output register. Depends on itp_pkg, itp_ram.
module itp_dp import itp_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  itp_cmd_t    cmd,
  input  logic [7:0]  ch,
  input  logic        out_stall,
  output itp_stat_t   stat,
  output logic        out_valid,
  output logic [7:0]  out_ch,
  output logic        out_last,
  output logic        empty_res,
  output logic        overflow
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam logic [CW-1:0] LEN = CW'(MAX_LEN);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);

  logic [CW-1:0] char_count, char_idx, depth, res_count, res_idx;
  logic          dropped, ovf;
  logic [2:0]    top;
  logic [7:0]    cur;

  logic [CW-1:0] char_idx_m1, depth_m2, res_idx_m1;
  logic [7:0]    char_rdata, res_rdata;
  logic [2:0]    stack_rdata, push_code;
  logic          res_we;
  logic [7:0]    res_wdata;
  logic          out_free;

  assign char_idx_m1 = char_idx - ONE;
  assign depth_m2    = depth - TWO;
  assign res_idx_m1  = res_idx - ONE;
  assign push_code   = (stat.cls == CLS_OPEN) ? CODE_OPEN : op_code(cur);
  assign res_we      = (cmd.emit_cur || cmd.pop_emit) && (res_count < LEN);
  assign res_wdata   = cmd.emit_cur ? cur : code_char(top);
  assign out_free    = !out_valid || !out_stall;

  itp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_char_ram (
    .clk   (clk),
    .we    (cmd.load_char && (char_count < LEN)),
    .waddr (char_count[AW-1:0]),
    .wdata (ch),
    .re    (cmd.scan_read),
    .raddr (char_idx_m1[AW-1:0]),
    .rdata (char_rdata)
  );

  itp_ram #(.WIDTH(3), .DEPTH(MAX_LEN)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.push && (depth < LEN)),
    .waddr (depth[AW-1:0]),
    .wdata (push_code),
    .re    ((cmd.pop_emit || cmd.pop_drop) && (depth > ONE)),
    .raddr (depth_m2[AW-1:0]),
    .rdata (stack_rdata)
  );

  itp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_count[AW-1:0]),
    .wdata (res_wdata),
    .re    (cmd.emit_read),
    .raddr (res_idx_m1[AW-1:0]),
    .rdata (res_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      char_idx   <= '0;
      depth      <= '0;
      res_count  <= '0;
      res_idx    <= '0;
      dropped    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load_char) begin
        if (char_count < LEN) begin
          char_count <= char_count + ONE;
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.scan_start) begin
        char_idx   <= char_count;
        char_count <= '0;
        dropped    <= 1'b0;
        depth      <= '0;
        res_count  <= '0;
      end
      if (cmd.scan_read) begin
        char_idx <= char_idx_m1;
      end
      if (cmd.push && (depth < LEN)) begin
        depth <= depth + ONE;
      end
      if ((cmd.pop_emit || cmd.pop_drop) && (depth != '0)) begin
        depth <= depth - ONE;
      end
      if (res_we) begin
        res_count <= res_count + ONE;
      end
      if (cmd.emit_start) begin
        res_idx <= res_count;
      end
      if (cmd.emit_read) begin
        res_idx <= res_idx_m1;
      end
      if (cmd.emit_put || cmd.emit_empty) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ovf <= dropped;
    end
    if (cmd.load_cur) begin
      cur <= char_rdata;
    end
    if (cmd.push) begin
      top <= push_code;
    end else if (cmd.load_top) begin
      top <= stack_rdata;
    end
    if (cmd.emit_put) begin
      out_ch    <= res_rdata;
      out_last  <= (res_idx == '0);
      empty_res <= 1'b0;
      overflow  <= ovf;
    end else if (cmd.emit_empty) begin
      out_ch    <= 8'd0;
      out_last  <= 1'b1;
      empty_res <= 1'b1;
      overflow  <= ovf;
    end
  end

  always_comb begin
    stat                = '0;
    stat.cls            = classify(cur);
    stat.cur_code       = op_code(cur);
    stat.top_code       = top;
    stat.depth_zero     = (depth == '0);
    stat.char_idx_zero  = (char_idx == '0);
    stat.res_count_zero = (res_count == '0);
    stat.res_idx_zero   = (res_idx == '0);
    stat.out_free       = out_free;
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= LEN)
    else $error("operator stack depth beyond buffer size");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_emit || cmd.pop_drop) |-> (depth != '0))
    else $error("pop issued on empty operator stack");

  a_result_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_cur || cmd.pop_emit) |-> (res_count < LEN))
    else $error("result written with result buffer full");

  a_put_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_put || cmd.emit_empty) |-> out_free)
    else $error("output register overwritten while stalled");

  a_put_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_put || cmd.emit_empty) |=> out_valid)
    else $error("output register loaded without valid");

endmodule

/* src/infix_to_prefix_converter.sv */
// infix_to_prefix_converter: top level, infix to prefix conversion of one
// expression at a time. Depends on itp_pkg, itp_ctrl, itp_dp, itp_ram.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  input    | in_valid / in_stall   | ch[7:0], last
//  output   | out_valid / out_stall | out_ch[7:0], out_last, empty_res,
//           |                       | overflow
//
// Steps: each character is taken while in_valid is high; after the last one,
// a setup step, then a read, a fetch and a decide step per scanned character.
// Every pop, of an operator or of a parenthesis, is followed by a reload step
// (the operator stack RAM is reread to refresh the cached top); the scan and
// the drain each close with a step of their own, and each result character is
// emitted by a registered result RAM read, then an output register load.
// in_stall is high from the last character until the final result has been
// loaded into the output register; that result may still wait while the
// next expression starts loading.
// Reset (rst, synchronous) clears counters, controller state and out_valid;
// the buffers need no clearing since only entries below the counts are read.
// out_stall holds the output register and stops emission; nothing is lost.
module infix_to_prefix_converter import itp_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_ch,
  output logic       out_last,
  output logic       empty_res,
  output logic       overflow
);

  itp_cmd_t  cmd;
  itp_stat_t stat;

  // Sequencer: decides every step of load, scan, pop, drain and emit.
  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Storage and counters; executes the commands, reports status.
  itp_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ch        (ch),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ch    (out_ch),
    .out_last  (out_last),
    .empty_res (empty_res),
    .overflow  (overflow)
  );

endmodule
